@@ rtl/core/ssd_pkg.sv @@
`default_nettype none
package ssd_pkg;

    localparam int OUT_BITS   = 25;
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage
`default_nettype wire

@@ rtl/core/ssd_front.sv @@
`default_nettype none
module ssd_front #(
    parameter int COORD_BITS = 16,
    localparam int DW   = COORD_BITS + 1,
    localparam int DOTW = 2 * DW + 2,
    localparam int PW   = 2 * DOTW + 1,
    localparam int EW   = 9 * DW + 4 * PW
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         seg_valid,
    output logic                              seg_stall,
    input  wire logic signed [COORD_BITS-1:0] p1s [3],
    input  wire logic signed [COORD_BITS-1:0] p1e [3],
    input  wire logic signed [COORD_BITS-1:0] p2s [3],
    input  wire logic signed [COORD_BITS-1:0] p2e [3],
    input  wire ssd_pkg::q_status_t           q_status,
    output logic                              push,
    output logic [EW-1:0]                     push_data
);

    logic fen;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    logic signed [DW-1:0] u1_reg [3], vv1_reg [3], w1_reg [3];
    logic signed [DW-1:0] u2_reg [3], vv2_reg [3], w2_reg [3];
    logic signed [DW-1:0] u3_reg [3], vv3_reg [3], w3_reg [3];
    logic signed [DW-1:0] u4_reg [3], vv4_reg [3], w4_reg [3];
    logic signed [DW-1:0] u5_reg [3], vv5_reg [3], w5_reg [3];

    logic signed [DOTW-1:0] a2_reg, b2_reg, c2_reg, d2_reg, e2_reg;
    logic signed [DOTW-1:0] a3_reg, b3_reg, c3_reg, d3_reg, e3_reg;
    logic signed [DOTW-1:0] a4_reg, b4_reg, d4_reg;
    logic signed [PW-1:0]   dd3_reg, sn3_reg, tn3_reg;
    logic signed [PW-1:0]   sn4_reg, sd4_reg, tn4_reg, td4_reg;
    logic signed [PW-1:0]   sn5_reg, sd5_reg, tn5_reg, td5_reg;

    logic signed [DOTW-1:0] a_next, b_next, c_next, d_next, e_next;
    logic signed [PW-1:0]   sn4_next, sd4_next, tn4_next, td4_next;
    logic signed [PW-1:0]   sn5_next, sd5_next, tn5_next, td5_next, m5;
    logic signed [2*DW-1:0] pa [3], pb [3], pc [3], pd [3], pe [3];

    assign fen       = !v5_reg || !q_status.full;
    assign seg_stall = !fen;
    assign push      = v5_reg && !q_status.full;

    always_comb
    begin
        a_next = '0; b_next = '0; c_next = '0; d_next = '0; e_next = '0;
        for (int k = 0; k < 3; k++)
        begin
            pa[k] = u1_reg[k] * u1_reg[k];
            pb[k] = u1_reg[k] * vv1_reg[k];
            pc[k] = vv1_reg[k] * vv1_reg[k];
            pd[k] = u1_reg[k] * w1_reg[k];
            pe[k] = vv1_reg[k] * w1_reg[k];
            a_next = a_next + DOTW'(pa[k]);
            b_next = b_next + DOTW'(pb[k]);
            c_next = c_next + DOTW'(pc[k]);
            d_next = d_next + DOTW'(pd[k]);
            e_next = e_next + DOTW'(pe[k]);
        end
    end

    // first clamp of s
    always_comb
    begin
        sn4_next = sn3_reg;
        sd4_next = dd3_reg;
        tn4_next = tn3_reg;
        td4_next = dd3_reg;
        if (dd3_reg == '0)
        begin
            sn4_next = '0;
            sd4_next = PW'(1);
            tn4_next = PW'(e3_reg);
            td4_next = PW'(c3_reg);
        end
        else if (sn3_reg < 0)
        begin
            sn4_next = '0;
            tn4_next = PW'(e3_reg);
            td4_next = PW'(c3_reg);
        end
        else if (sn3_reg > dd3_reg)
        begin
            sn4_next = dd3_reg;
            tn4_next = PW'(e3_reg) + PW'(b3_reg);
            td4_next = PW'(c3_reg);
        end
    end

    // clamp of t with re-clamp of s, then zero cleanup
    always_comb
    begin
        sn5_next = sn4_reg;
        sd5_next = sd4_reg;
        tn5_next = tn4_reg;
        td5_next = td4_reg;
        m5       = '0;
        if (tn4_reg < 0 || tn4_reg > td4_reg)
        begin
            if (tn4_reg < 0)
            begin
                tn5_next = '0;
                m5 = -PW'(d4_reg);
            end
            else
            begin
                tn5_next = td4_reg;
                m5 = PW'(b4_reg) - PW'(d4_reg);
            end
            if (m5 < 0)
                sn5_next = '0;
            else if (m5 > PW'(a4_reg))
                sn5_next = sd4_reg;
            else
            begin
                sn5_next = m5;
                sd5_next = PW'(a4_reg);
            end
        end
        if (sn5_next == '0 || sd5_next == '0)
        begin
            sn5_next = '0;
            sd5_next = PW'(1);
        end
        if (tn5_next == '0 || td5_next == '0)
        begin
            tn5_next = '0;
            td5_next = PW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (fen)
        begin
            v1_reg <= seg_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fen)
        begin
            for (int k = 0; k < 3; k++)
            begin
                u1_reg[k]  <= DW'(p1e[k]) - DW'(p1s[k]);
                vv1_reg[k] <= DW'(p2e[k]) - DW'(p2s[k]);
                w1_reg[k]  <= DW'(p1s[k]) - DW'(p2s[k]);
            end
            u2_reg <= u1_reg; vv2_reg <= vv1_reg; w2_reg <= w1_reg;
            u3_reg <= u2_reg; vv3_reg <= vv2_reg; w3_reg <= w2_reg;
            u4_reg <= u3_reg; vv4_reg <= vv3_reg; w4_reg <= w3_reg;
            u5_reg <= u4_reg; vv5_reg <= vv4_reg; w5_reg <= w4_reg;

            a2_reg <= a_next; b2_reg <= b_next; c2_reg <= c_next;
            d2_reg <= d_next; e2_reg <= e_next;

            a3_reg <= a2_reg; b3_reg <= b2_reg; c3_reg <= c2_reg;
            d3_reg <= d2_reg; e3_reg <= e2_reg;
            dd3_reg <= PW'(a2_reg) * PW'(c2_reg) - PW'(b2_reg) * PW'(b2_reg);
            sn3_reg <= PW'(b2_reg) * PW'(e2_reg) - PW'(c2_reg) * PW'(d2_reg);
            tn3_reg <= PW'(a2_reg) * PW'(e2_reg) - PW'(b2_reg) * PW'(d2_reg);

            a4_reg <= a3_reg; b4_reg <= b3_reg; d4_reg <= d3_reg;
            sn4_reg <= sn4_next; sd4_reg <= sd4_next;
            tn4_reg <= tn4_next; td4_reg <= td4_next;

            sn5_reg <= sn5_next; sd5_reg <= sd5_next;
            tn5_reg <= tn5_next; td5_reg <= td5_next;
        end
    end

    assign push_data = {u5_reg[0], u5_reg[1], u5_reg[2],
                        vv5_reg[0], vv5_reg[1], vv5_reg[2],
                        w5_reg[0], w5_reg[1], w5_reg[2],
                        sn5_reg, sd5_reg, tn5_reg, td5_reg};

endmodule
`default_nettype wire

@@ rtl/core/ssd_queue.sv @@
`default_nettype none
module ssd_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [WIDTH-1:0]  push_data,
    input  wire logic              pop,
    output logic [WIDTH-1:0]       pop_data,
    output ssd_pkg::q_status_t     status
);

    localparam int DEPTH = ssd_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_reg, rd_reg;
    logic [AW:0]      cnt_reg;
    logic             do_push, do_pop;

    assign status.full  = (cnt_reg == (AW+1)'(DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= wr_reg + AW'(1);
            if (do_pop)
                rd_reg <= rd_reg + AW'(1);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + (AW+1)'(1);
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_data;
    end

endmodule
`default_nettype wire

@@ rtl/core/ssd_back.sv @@
`default_nettype none
module ssd_mul #(
    parameter int AW = 32,
    parameter int BW = 32,
    localparam int NA = (AW + 31) / 32,
    localparam int NB = (BW + 31) / 32,
    localparam int RW = 32 * NA + 32,
    localparam int PD = 32 * (NA + NB)
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [AW-1:0] a,
    input  wire logic [BW-1:0] b,
    output logic [AW+BW-1:0]   p
);

    logic [32*NA-1:0] a_reg [NB];
    logic [32*NB-1:0] b_reg [NB];
    logic [PD-1:0]    acc_reg [NB];

    // one 32-bit slice of b times all of a; even and odd partial products
    // do not overlap, so a single add joins them
    function automatic logic [RW-1:0] row(input logic [32*NA-1:0] x,
                                          input logic [31:0] y);
        logic [RW-1:0] ev, od;
        logic [63:0]   pp;
        ev = '0;
        od = '0;
        for (int i = 0; i < NA; i++)
        begin
            pp = x[i*32 +: 32] * y;
            if ((i & 1) == 0)
                ev[i*32 +: 64] = pp;
            else
                od[i*32 +: 64] = pp;
        end
        return ev + od;
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg[0] <= (32*NA)'(a);
            b_reg[0] <= (32*NB)'(b);
            for (int j = 1; j < NB; j++)
            begin
                a_reg[j] <= a_reg[j-1];
                b_reg[j] <= b_reg[j-1];
            end
            acc_reg[0] <= PD'(row(a_reg[0], b_reg[0][31:0]));
            for (int j = 1; j < NB; j++)
                acc_reg[j] <= acc_reg[j-1]
                            + (PD'(row(a_reg[j], b_reg[j][j*32 +: 32])) << (32 * j));
        end
    end

    assign p = acc_reg[NB-1][AW+BW-1:0];

endmodule

module ssd_back #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8,
    localparam int DW   = COORD_BITS + 1,
    localparam int DOTW = 2 * DW + 2,
    localparam int PW   = 2 * DOTW + 1,
    localparam int EW   = 9 * DW + 4 * PW,
    localparam int CW   = PW - 1,
    localparam int MW   = 2 * CW,
    localparam int XW   = MW + DW + 2,
    localparam int NW   = 2 * XW,
    localparam int TW   = 2 * XW + 2 + 2 * FRAC_BITS,
    localparam int OB   = ssd_pkg::OUT_BITS,
    localparam int SW   = TW + OB + 2,
    localparam int NM   = (MW + 31) / 32,
    localparam int L1   = (CW + 31) / 32 + 1,
    localparam int L2   = (XW + 31) / 32 + 1,
    localparam int VL   = L1 + L2 + 4,
    localparam int CDW  = 9 * (DW + 1)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ssd_pkg::q_status_t   q_status,
    input  wire logic [EW-1:0]        pop_data,
    output logic                      pop,
    output logic                      dist_valid,
    input  wire logic                 dist_stall,
    output logic [OB-1:0]             distance
);

    logic ben;
    logic signed [DW-1:0] uq [3], vq [3], wq [3];
    logic signed [PW-1:0] snq, sdq, tnq, tdq;

    logic                 vp_reg [VL];
    logic [CDW-1:0]       cd_next;
    logic [CDW-1:0]       cd_reg [L1];
    logic [MW-1:0]        m_p, p1_p, p2_p;
    logic [MW-1:0]        mx1_reg, mx2_reg, mx3_reg;
    logic signed [XW-1:0] tw_reg [3], tu_reg [3], tv_reg [3];
    logic signed [XW-1:0] x2_reg [3];
    logic [XW-1:0]        ax_reg [3];
    logic [NW-1:0]        sq_p [3];
    logic [NW-1:0]        n_p;
    logic [NW-1:0]        n3_reg;
    logic [SW-1:0]        r3_reg;
    logic [2*XW+1:0]      sum_next;

    logic          sv_reg [OB];
    logic [SW-1:0] sr_reg [OB];
    logic [SW-1:0] ss_reg [OB];
    logic [NW-1:0] sn_reg [OB];
    logic [OB-1:0] sq_reg [OB];

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] x);
        return x[DW-1] ? DW'(-x) : DW'(x);
    endfunction

    // signed coordinate {sign, magnitude} times a wide unsigned factor
    function automatic logic [XW-1:0] scale(input logic [MW-1:0] m,
                                            input logic [DW:0] c);
        logic [32*NM-1:0]  mp;
        logic [32*NM+31:0] ev, od, mag_p;
        logic [63:0]       pp;
        mp = (32*NM)'(m);
        ev = '0;
        od = '0;
        for (int i = 0; i < NM; i++)
        begin
            pp = mp[i*32 +: 32] * 32'(c[DW-1:0]);
            if ((i & 1) == 0)
                ev[i*32 +: 64] = pp;
            else
                od[i*32 +: 64] = pp;
        end
        mag_p = ev + od;
        return c[DW] ? XW'(-mag_p) : XW'(mag_p);
    endfunction

    assign ben = !dist_valid || !dist_stall;
    assign pop = ben && !q_status.empty;

    assign {uq[0], uq[1], uq[2], vq[0], vq[1], vq[2], wq[0], wq[1], wq[2],
            snq, sdq, tnq, tdq} = pop_data;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cd_next[k*(DW+1) +: DW+1]     = {uq[k][DW-1], mag(uq[k])};
            cd_next[(3+k)*(DW+1) +: DW+1] = {vq[k][DW-1], mag(vq[k])};
            cd_next[(6+k)*(DW+1) +: DW+1] = {wq[k][DW-1], mag(wq[k])};
        end
    end

    // clamped parameters are never negative
    ssd_mul #(.AW(CW), .BW(CW)) u_mul_m (
        .clk (clk),
        .en  (ben),
        .a   (sdq[CW-1:0]),
        .b   (tdq[CW-1:0]),
        .p   (m_p)
    );

    ssd_mul #(.AW(CW), .BW(CW)) u_mul_s (
        .clk (clk),
        .en  (ben),
        .a   (snq[CW-1:0]),
        .b   (tdq[CW-1:0]),
        .p   (p1_p)
    );

    ssd_mul #(.AW(CW), .BW(CW)) u_mul_t (
        .clk (clk),
        .en  (ben),
        .a   (tnq[CW-1:0]),
        .b   (sdq[CW-1:0]),
        .p   (p2_p)
    );

    for (genvar k = 0; k < 3; k++)
    begin : g_sq
        ssd_mul #(.AW(XW), .BW(XW)) u_sq (
            .clk (clk),
            .en  (ben),
            .a   (ax_reg[k]),
            .b   (ax_reg[k]),
            .p   (sq_p[k])
        );
    end

    ssd_mul #(.AW(XW), .BW(XW)) u_sq_m (
        .clk (clk),
        .en  (ben),
        .a   (XW'(mx3_reg)),
        .b   (XW'(mx3_reg)),
        .p   (n_p)
    );

    assign sum_next = (2*XW+2)'(sq_p[0]) + (2*XW+2)'(sq_p[1]) + (2*XW+2)'(sq_p[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < VL; j++)
                vp_reg[j] <= 1'b0;
        end
        else if (ben)
        begin
            vp_reg[0] <= !q_status.empty;
            for (int j = 1; j < VL; j++)
                vp_reg[j] <= vp_reg[j-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ben)
        begin
            cd_reg[0] <= cd_next;
            for (int j = 1; j < L1; j++)
                cd_reg[j] <= cd_reg[j-1];
            for (int k = 0; k < 3; k++)
            begin
                tu_reg[k] <= scale(p1_p, cd_reg[L1-1][k*(DW+1) +: DW+1]);
                tv_reg[k] <= scale(p2_p, cd_reg[L1-1][(3+k)*(DW+1) +: DW+1]);
                tw_reg[k] <= scale(m_p, cd_reg[L1-1][(6+k)*(DW+1) +: DW+1]);
                x2_reg[k] <= tw_reg[k] + tu_reg[k] - tv_reg[k];
                ax_reg[k] <= x2_reg[k][XW-1] ? XW'(-x2_reg[k]) : XW'(x2_reg[k]);
            end
            mx1_reg <= m_p;
            mx2_reg <= mx1_reg;
            mx3_reg <= mx2_reg;
            r3_reg  <= SW'(sum_next) << (2 * FRAC_BITS);
            n3_reg  <= n_p;
        end
    end

    // one result bit per stage: residual r, s = root * m^2
    for (genvar i = 0; i < OB; i++)
    begin : g_root
        localparam int B = OB - 1 - i;
        logic          vin;
        logic [SW-1:0] rin, sin, cand;
        logic [NW-1:0] nin;
        logic [OB-1:0] qin;

        if (i == 0)
        begin : g_first
            assign vin = vp_reg[VL-1];
            assign rin = r3_reg;
            assign sin = '0;
            assign nin = n3_reg;
            assign qin = '0;
        end
        else
        begin : g_next
            assign vin = sv_reg[i-1];
            assign rin = sr_reg[i-1];
            assign sin = ss_reg[i-1];
            assign nin = sn_reg[i-1];
            assign qin = sq_reg[i-1];
        end

        assign cand = (sin << (B + 1)) + (SW'(nin) << (2 * B));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sv_reg[i] <= 1'b0;
            else if (ben)
                sv_reg[i] <= vin;
        end

        always_ff @(posedge clk)
        begin
            if (ben)
            begin
                sn_reg[i] <= nin;
                if (cand <= rin)
                begin
                    sr_reg[i] <= rin - cand;
                    ss_reg[i] <= sin + (SW'(nin) << B);
                    sq_reg[i] <= qin | (OB'(1) << B);
                end
                else
                begin
                    sr_reg[i] <= rin;
                    ss_reg[i] <= sin;
                    sq_reg[i] <= qin;
                end
            end
        end
    end

    assign dist_valid = sv_reg[OB-1];
    assign distance   = sq_reg[OB-1];

endmodule
`default_nettype wire

@@ rtl/core/segment_segment_distance.sv @@
`default_nettype none
// Shortest distance between two 3D segments.
// Input channel: seg_valid / seg_stall with twelve signed coordinates
// (start and end of segment 1, then of segment 2). A transaction is taken
// at a rising edge with seg_valid high and seg_stall low.
// Output channel: dist_valid / dist_stall carrying distance, unsigned with
// FRAC_BITS fraction bits, truncated, saturating to all ones.
// Throughput: one transaction per cycle while the output is not stalled.
// Pipeline: five front stages (dot products, determinant, clamping), the
// 4-entry queue, fifteen back stages (pipelined parameter products,
// scaled difference vector, squared length) and 25 root stages, one
// result bit each.
// While dist_valid and dist_stall are both high the back pipeline holds;
// the front keeps taking transactions until the queue and its own stages
// fill, then raises seg_stall.
// Reset empties all stages and the queue; dist_valid is low and seg_stall
// low right after reset.
module segment_segment_distance #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         seg_valid,
    output logic                              seg_stall,
    input  wire logic signed [COORD_BITS-1:0] seg1_start_x,
    input  wire logic signed [COORD_BITS-1:0] seg1_start_y,
    input  wire logic signed [COORD_BITS-1:0] seg1_start_z,
    input  wire logic signed [COORD_BITS-1:0] seg1_end_x,
    input  wire logic signed [COORD_BITS-1:0] seg1_end_y,
    input  wire logic signed [COORD_BITS-1:0] seg1_end_z,
    input  wire logic signed [COORD_BITS-1:0] seg2_start_x,
    input  wire logic signed [COORD_BITS-1:0] seg2_start_y,
    input  wire logic signed [COORD_BITS-1:0] seg2_start_z,
    input  wire logic signed [COORD_BITS-1:0] seg2_end_x,
    input  wire logic signed [COORD_BITS-1:0] seg2_end_y,
    input  wire logic signed [COORD_BITS-1:0] seg2_end_z,
    output logic                              dist_valid,
    input  wire logic                         dist_stall,
    output logic [ssd_pkg::OUT_BITS-1:0]      distance
);

    localparam int DW   = COORD_BITS + 1;
    localparam int DOTW = 2 * DW + 2;
    localparam int PW   = 2 * DOTW + 1;
    localparam int EW   = 9 * DW + 4 * PW;

    logic signed [COORD_BITS-1:0] p1s [3], p1e [3], p2s [3], p2e [3];
    ssd_pkg::q_status_t q_status;
    logic               push, pop;
    logic [EW-1:0]      push_data, pop_data;

    assign p1s = '{seg1_start_x, seg1_start_y, seg1_start_z};
    assign p1e = '{seg1_end_x, seg1_end_y, seg1_end_z};
    assign p2s = '{seg2_start_x, seg2_start_y, seg2_start_z};
    assign p2e = '{seg2_end_x, seg2_end_y, seg2_end_z};

    ssd_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg_valid (seg_valid),
        .seg_stall (seg_stall),
        .p1s       (p1s),
        .p1e       (p1e),
        .p2s       (p2s),
        .p2e       (p2e),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    ssd_queue #(.WIDTH(EW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    ssd_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .pop_data   (pop_data),
        .pop        (pop),
        .dist_valid (dist_valid),
        .dist_stall (dist_stall),
        .distance   (distance)
    );

endmodule
`default_nettype wire

@@ rtl/core/ssd_checker.sv @@
`default_nettype none
module ssd_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         seg_stall,
    input wire logic                         dist_valid,
    input wire logic                         dist_stall,
    input wire logic [ssd_pkg::OUT_BITS-1:0] distance
);

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !dist_valid)
        else $error("result valid during reset");

    a_ready_after_reset: assert property (@(posedge clk)
        !$past(rst_n) && rst_n |-> !seg_stall)
        else $error("input stalled right after reset");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        dist_valid && dist_stall |=> dist_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        dist_valid && dist_stall |=> $stable(distance))
        else $error("result changed while stalled");

endmodule

bind segment_segment_distance ssd_checker u_ssd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .seg_stall  (seg_stall),
    .dist_valid (dist_valid),
    .dist_stall (dist_stall),
    .distance   (distance)
);
`default_nettype wire
